>>> src/skt_pkg.sv
// Shared types and constants for the scalar 2D Kalman tracker.
// Holds the operation codes, the register indexes, the microcode word format and the ROM.
// Used by skt_divider and scalar_kalman_2d_tracker_unit; depends on nothing.
`timescale 1ns / 1ps

package skt_pkg;

	// Gain is an unsigned fraction with this many fraction bits, 0 to 1.0 inclusive.
	localparam int GAIN_BITS = 16;
	localparam int GAIN_W    = GAIN_BITS + 1;
	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

	// Configuration register indexes.
	localparam logic CFG_PNV = 1'b0;
	localparam logic CFG_MNV = 1'b1;

	localparam int UPC_W = 4;
	typedef logic [UPC_W-1:0] upc_t;

	typedef enum logic [1:0] {
		FUNC_LOAD       = 2'd0,
		FUNC_PREDICT    = 2'd1,
		FUNC_UPDATE     = 2'd2,
		FUNC_PRED_UPD_R = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_PRED,
		OP_DIV_INIT,
		OP_DIV_WAIT,
		OP_MUL_X,
		OP_ADD_X,
		OP_MUL_Y,
		OP_ADD_Y,
		OP_MUL_V,
		OP_ADD_V,
		OP_SET_R,
		OP_OUT
	} uc_op_t;

	typedef enum logic [1:0] {
		COND_NEXT,      // go to the next field
		COND_DIV,       // hold while the divider runs, then go to next
		COND_SKIP_F3,   // fall through for func 3, else go to next
		COND_END        // hand over the result, then go idle
	} uc_cond_t;

	typedef struct packed {
		uc_op_t   op;
		uc_cond_t cond;
		upc_t     next;
	} uc_word_t;

	localparam upc_t A_LOAD     = 4'd0;
	localparam upc_t A_PRED     = 4'd1;
	localparam upc_t A_PRED_F3  = 4'd2;
	localparam upc_t A_DIV_INIT = 4'd3;
	localparam upc_t A_DIV_WAIT = 4'd4;
	localparam upc_t A_MUL_X    = 4'd5;
	localparam upc_t A_ADD_X    = 4'd6;
	localparam upc_t A_MUL_Y    = 4'd7;
	localparam upc_t A_ADD_Y    = 4'd8;
	localparam upc_t A_MUL_V    = 4'd9;
	localparam upc_t A_ADD_V    = 4'd10;
	localparam upc_t A_SET_R    = 4'd11;
	localparam upc_t A_OUT      = 4'd12;

	function automatic uc_word_t ucode_rom(input upc_t addr);
		uc_word_t w;
		unique case (addr)
			A_LOAD:     w = '{OP_LOAD,     COND_NEXT,    A_OUT};
			A_PRED:     w = '{OP_PRED,     COND_NEXT,    A_OUT};
			A_PRED_F3:  w = '{OP_PRED,     COND_NEXT,    A_DIV_INIT};
			A_DIV_INIT: w = '{OP_DIV_INIT, COND_NEXT,    A_DIV_WAIT};
			A_DIV_WAIT: w = '{OP_DIV_WAIT, COND_DIV,     A_MUL_X};
			A_MUL_X:    w = '{OP_MUL_X,    COND_NEXT,    A_ADD_X};
			A_ADD_X:    w = '{OP_ADD_X,    COND_NEXT,    A_MUL_Y};
			A_MUL_Y:    w = '{OP_MUL_Y,    COND_NEXT,    A_ADD_Y};
			A_ADD_Y:    w = '{OP_ADD_Y,    COND_NEXT,    A_MUL_V};
			A_MUL_V:    w = '{OP_MUL_V,    COND_NEXT,    A_ADD_V};
			A_ADD_V:    w = '{OP_ADD_V,    COND_SKIP_F3, A_OUT};
			A_SET_R:    w = '{OP_SET_R,    COND_NEXT,    A_OUT};
			A_OUT:      w = '{OP_OUT,      COND_END,     A_OUT};
			default:    w = '{OP_NOP,      COND_NEXT,    A_OUT};
		endcase
		return w;
	endfunction

	function automatic upc_t entry_addr(input func_t f);
		upc_t a;
		unique case (f)
			FUNC_LOAD:       a = A_LOAD;
			FUNC_PREDICT:    a = A_PRED;
			FUNC_UPDATE:     a = A_DIV_INIT;
			FUNC_PRED_UPD_R: a = A_PRED_F3;
		endcase
		return a;
	endfunction

endpackage

>>> src/skt_divider.sv
// Radix-2 restoring divider for the Kalman gain: floor(p * 2^GAIN_BITS / den).
// One quotient bit per cycle; a zero denominator gives a gain of zero.
// Depends on skt_pkg for the gain width.
`timescale 1ns / 1ps

module skt_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [31:0]                   p,
	input  logic [32:0]                   den,
	output logic                          busy,
	output logic [skt_pkg::GAIN_W-1:0]    gain
);

	localparam int CNT_W = $clog2(skt_pkg::GAIN_W + 1);

	logic [32:0]                rem_q;
	logic [32:0]                den_q;
	logic [skt_pkg::GAIN_W-1:0] quo_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       nb_q;
	logic                       zero_q;

	logic [33:0] trial;
	logic [33:0] diff;
	logic        fits;

	// The dividend is p followed by GAIN_BITS zeros. Its top bits (p >> 1) are
	// already below the divisor, so only GAIN_W quotient bits remain.
	assign trial = {rem_q, nb_q};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(skt_pkg::GAIN_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {2'b00, p[31:1]};
			nb_q   <= p[0];
			den_q  <= den;
			quo_q  <= '0;
			zero_q <= den == '0;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[32:0] : trial[32:0];
			nb_q  <= 1'b0;
			quo_q <= {quo_q[skt_pkg::GAIN_W-2:0], fits};
		end
	end

	assign busy = cnt_q != '0;
	assign gain = zero_q ? '0 : quo_q;

endmodule

>>> src/scalar_kalman_2d_tracker_unit.sv
// Scalar isotropic Kalman tracker for a 2D position: top level with the
// microcode sequencer, the datapath registers and the configuration port.
// Depends on skt_pkg and skt_divider.
`timescale 1ns / 1ps

// The sequencer works on one item at a time. Load and predict go from their
// own step straight to the output step; update and predict-update-reset wait
// for the bit-serial gain divider, then use one shared 33x17 multiplier in
// turn for x, y and the variance. A new input is taken as soon as the
// sequencer is idle, even while the previous result still waits at the
// output register. Configuration writes are always ready and take effect at
// once; write them only while idle.
// FRAC_BITS sets the fixed-point format, which fixes the reset value (1.0) of
// the measurement noise variance.
module scalar_kalman_2d_tracker_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic [31:0]        load_variance,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] est_x,
	output logic signed [31:0] est_y,
	output logic [31:0]        est_variance
);

	localparam logic [31:0] MNV_RESET = 32'(64'd1 << FRAC_BITS);
	localparam int          PROD_W    = 33 + skt_pkg::GAIN_W;
	localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (skt_pkg::GAIN_BITS - 1);

	// Sequencer state.
	logic               busy_q;
	skt_pkg::upc_t      upc_q;
	skt_pkg::func_t     func_q;
	skt_pkg::uc_word_t  cw;
	logic               busy_d;
	skt_pkg::upc_t      upc_d;
	logic               in_take;
	logic               out_load;

	// Datapath state.
	logic [31:0]        pnv_q;
	logic [31:0]        mnv_q;
	logic signed [31:0] mean_x_q;
	logic signed [31:0] mean_y_q;
	logic [31:0]        var_q;
	logic signed [31:0] zx_q;
	logic signed [31:0] zy_q;
	logic [31:0]        lvar_q;
	logic [32:0]        mag_x_q;
	logic [32:0]        mag_y_q;
	logic               neg_x_q;
	logic               neg_y_q;
	logic [PROD_W-1:0]  prod_q;
	logic               out_valid_q;
	logic signed [31:0] est_x_q;
	logic signed [31:0] est_y_q;
	logic [31:0]        est_var_q;

	// Datapath logic.
	logic                       div_start;
	logic                       div_busy;
	logic [skt_pkg::GAIN_W-1:0] gain;
	logic [32:0]                den;
	logic [32:0]                pred_sum;
	logic [31:0]                pred_var;
	logic signed [32:0]         innov_x;
	logic signed [32:0]         innov_y;
	logic [32:0]                mul_a;
	logic [skt_pkg::GAIN_W-1:0] mul_b;
	logic [PROD_W-1:0]          rounded;
	logic [33:0]                step;
	logic signed [31:0]         moved_x;
	logic signed [31:0]         moved_y;
	logic [31:0]                scaled_var;

	function automatic logic signed [31:0] move_mean(input logic signed [31:0] m,
			input logic [33:0] d, input logic neg);
		logic signed [35:0] m_ext;
		logic signed [35:0] d_ext;
		logic signed [35:0] sum;
		logic signed [31:0] res;
		m_ext = 36'(m);
		d_ext = $signed({2'b00, d});
		sum   = neg ? m_ext - d_ext : m_ext + d_ext;
		if (sum > 36'sh0_7FFF_FFFF) begin
			res = 32'sh7FFF_FFFF;
		end else if (sum < -36'sh0_8000_0000) begin
			res = -32'sh8000_0000;
		end else begin
			res = sum[31:0];
		end
		return res;
	endfunction

	assign cw       = skt_pkg::ucode_rom(upc_q);
	assign in_stall = busy_q;
	assign in_take  = in_valid && !in_stall;
	assign out_load = busy_q && cw.op == skt_pkg::OP_OUT && !(out_valid_q && out_stall);

	// Next microcode address.
	always_comb begin
		busy_d = busy_q;
		upc_d  = upc_q;
		if (!busy_q) begin
			if (in_take) begin
				busy_d = 1'b1;
				upc_d  = skt_pkg::entry_addr(skt_pkg::func_t'(func));
			end
		end else begin
			unique case (cw.cond)
				skt_pkg::COND_NEXT: begin
					upc_d = cw.next;
				end
				skt_pkg::COND_DIV: begin
					if (!div_busy) begin
						upc_d = cw.next;
					end
				end
				skt_pkg::COND_SKIP_F3: begin
					upc_d = (func_q == skt_pkg::FUNC_PRED_UPD_R) ? upc_q + 1'b1 : cw.next;
				end
				skt_pkg::COND_END: begin
					if (out_load) begin
						busy_d = 1'b0;
					end
				end
			endcase
		end
	end

	// Control outputs decoded from the current control word.
	always_comb begin
		div_start = busy_q && cw.op == skt_pkg::OP_DIV_INIT;
		mul_a     = mag_x_q;
		mul_b     = gain;
		unique case (cw.op)
			skt_pkg::OP_MUL_Y: begin
				mul_a = mag_y_q;
			end
			skt_pkg::OP_MUL_V: begin
				mul_a = {1'b0, var_q};
				mul_b = skt_pkg::GAIN_ONE - gain;
			end
			default: begin
				mul_a = mag_x_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			upc_q  <= skt_pkg::A_LOAD;
		end else begin
			busy_q <= busy_d;
			upc_q  <= upc_d;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pnv_q <= '0;
			mnv_q <= MNV_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				skt_pkg::CFG_PNV: pnv_q <= cfg_data;
				skt_pkg::CFG_MNV: mnv_q <= cfg_data;
			endcase
		end
	end

	skt_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.p      (var_q),
		.den    (den),
		.busy   (div_busy),
		.gain   (gain)
	);

	assign den        = {1'b0, var_q} + {1'b0, mnv_q};
	assign pred_sum   = {1'b0, var_q} + {1'b0, pnv_q};
	assign pred_var   = pred_sum[32] ? 32'hFFFF_FFFF : pred_sum[31:0];
	assign innov_x    = 33'(zx_q) - 33'(mean_x_q);
	assign innov_y    = 33'(zy_q) - 33'(mean_y_q);
	assign rounded    = prod_q + HALF;
	assign step       = rounded[PROD_W-1:skt_pkg::GAIN_BITS];
	assign moved_x    = move_mean(mean_x_q, step, neg_x_q);
	assign moved_y    = move_mean(mean_y_q, step, neg_y_q);
	assign scaled_var = (step[33:32] != 2'b00) ? 32'hFFFF_FFFF : step[31:0];

	// State registers; the mean and variance reset to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_x_q <= '0;
			mean_y_q <= '0;
			var_q    <= '0;
		end else if (busy_q) begin
			unique case (cw.op)
				skt_pkg::OP_LOAD: begin
					mean_x_q <= zx_q;
					mean_y_q <= zy_q;
					var_q    <= lvar_q;
				end
				skt_pkg::OP_PRED:  var_q    <= pred_var;
				skt_pkg::OP_ADD_X: mean_x_q <= moved_x;
				skt_pkg::OP_ADD_Y: mean_y_q <= moved_y;
				skt_pkg::OP_ADD_V: var_q    <= scaled_var;
				skt_pkg::OP_SET_R: var_q    <= mnv_q;
				default: begin
					var_q <= var_q;
				end
			endcase
		end
	end

	// Operand and product registers.
	always_ff @(posedge clk) begin
		if (in_take) begin
			func_q <= skt_pkg::func_t'(func);
			zx_q   <= pos_x;
			zy_q   <= pos_y;
			lvar_q <= load_variance;
		end
		// The innovations are taken as the divider starts; the means are
		// still untouched at that point.
		if (div_start) begin
			neg_x_q <= innov_x[32];
			neg_y_q <= innov_y[32];
			mag_x_q <= innov_x[32] ? 33'(-innov_x) : 33'(innov_x);
			mag_y_q <= innov_y[32] ? 33'(-innov_y) : 33'(innov_y);
		end
		prod_q <= mul_a * mul_b;
	end

	// Output register: one result per item, held until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			est_x_q   <= mean_x_q;
			est_y_q   <= mean_y_q;
			est_var_q <= var_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign est_x        = est_x_q;
	assign est_y        = est_y_q;
	assign est_variance = est_var_q;

`ifndef NO_ASSERTIONS
	a_out_from_ucode: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_q && cw.op == skt_pkg::OP_OUT))
		else $error("result raised without the output step");

	a_div_done_before_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cw.op == skt_pkg::OP_MUL_X) |-> !div_busy)
		else $error("gain used while the divider is still running");

	a_take_starts_program: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> busy_q && (upc_q <= skt_pkg::A_PRED_F3 || upc_q == skt_pkg::A_DIV_INIT))
		else $error("accepted item did not start at an entry point");

	a_upc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> upc_q <= skt_pkg::A_OUT)
		else $error("microcode address out of range");
`endif

endmodule
